>>> src/rgbyuv_pkg.sv
// package: types, constants and helpers for the rgb to yuv 4:2:0 converter
`default_nettype none
package rgbyuv_pkg;

	localparam int unsigned CFG_W           = 13;
	localparam int unsigned APB_DW          = 32;
	localparam int unsigned APB_AW          = 3;
	localparam int unsigned MAX_DIM_DEFAULT = 4096;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	// unsigned q0.16 coefficients
	localparam logic [15:0] CY_R   = 16'd19595;
	localparam logic [15:0] CY_G   = 16'd38470;
	localparam logic [15:0] CY_B   = 16'd7471;
	localparam logic [15:0] CU_R   = 16'd11076;
	localparam logic [15:0] CU_G   = 16'd21692;
	localparam logic [15:0] C_HALF = 16'd32768;
	localparam logic [15:0] CV_G   = 16'd27460;
	localparam logic [15:0] CV_B   = 16'd5308;

	// q8.16 sums need 25 bits once the rounding constant is added
	localparam int unsigned SUM_W = 25;
	localparam logic [SUM_W-1:0] OFFSET_Q = 25'd8388608;
	localparam logic [SUM_W-1:0] ROUND_Q  = 25'd32768;

	localparam logic [8:0] LUMA_LO   = 9'd16;
	localparam logic [8:0] LUMA_HI   = 9'd235;
	localparam logic [8:0] CHROMA_LO = 9'd16;
	localparam logic [8:0] CHROMA_HI = 9'd240;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [7:0] luma;
		logic       chroma_valid;
		logic [7:0] blue_diff;
		logic [7:0] red_diff;
		logic       frame_end;
	} yuv_t;

	// round half up, drop the fraction, clamp into lo..hi
	function automatic logic [7:0] round_clamp(
		input logic [SUM_W-1:0] sum,
		input logic [8:0]       lo,
		input logic [8:0]       hi
	);
		logic [SUM_W-1:0] rounded;
		logic [8:0]       whole;
		rounded = sum + ROUND_Q;
		whole   = rounded[SUM_W-1:16];
		if (whole < lo) begin
			whole = lo;
		end else if (whole > hi) begin
			whole = hi;
		end
		return whole[7:0];
	endfunction

endpackage
`default_nettype wire

>>> src/rgb_to_yuv420_converter_unit.sv
// top level: streaming rgb to yuv 4:2:0 converter with frame position tracking
`default_nettype none
// Converts one RGB pixel per clock, in raster order, into a BT.601 full-range
// luma sample (clamped 16..235) and, at the top-left pixel of every complete
// 2x2 block, a U/V chroma pair (clamped 16..240); other pixels carry zero
// chroma with chroma_valid low. frame_end marks the last pixel of the frame.
// Throughput is one pixel per clock while res_stall stays low; each input
// beat passes the input register and then the result register, with the
// coefficient multiply, round and clamp logic between them. While a
// finished result waits on res_stall the input register takes at most one more
// beat, then pix_stall holds the input until the result beat goes out.
// Frame size comes from two APB registers: frame_width at 0x0 and
// frame_height at 0x4, 13 bits each, reset 640x480. Values below 2 act as 2
// and values above MAX_DIM act as MAX_DIM. Write them only while the block is
// idle; a size change keeps the current position, and a position at or past
// the new last column or row ends that line or frame.
module rgb_to_yuv420_converter_unit #(
	parameter int unsigned MAX_DIM = rgbyuv_pkg::MAX_DIM_DEFAULT
) (
	input  wire                               clk,
	input  wire                               arst_n,
	// pixel input
	input  wire                               pix_valid,
	output logic                              pix_stall,
	input  wire  rgbyuv_pkg::pixel_t          pix,
	// result output
	output logic                              res_valid,
	input  wire                               res_stall,
	output rgbyuv_pkg::yuv_t                  res,
	// configuration
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [rgbyuv_pkg::APB_AW-1:0]     paddr,
	input  wire  [rgbyuv_pkg::APB_DW-1:0]     pwdata,
	output logic [rgbyuv_pkg::APB_DW-1:0]     prdata,
	output logic                              pready
);
	import rgbyuv_pkg::*;

	// position counters span 0..MAX_DIM-1; dimension compares need room for MAX_DIM
	localparam int unsigned POS_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
	localparam int unsigned DIM_RAW_W = $clog2(MAX_DIM + 1);
	localparam int unsigned DIM_W = (DIM_RAW_W > CFG_W) ? DIM_RAW_W : CFG_W;

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;
	logic [CFG_W-1:0] cfg_rd;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[CFG_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_FRAME_WIDTH:  cfg_rd = frame_width_q;
			REG_FRAME_HEIGHT: cfg_rd = frame_height_q;
			default:          cfg_rd = '0;
		endcase
		prdata = APB_DW'(cfg_rd);
	end

	// ---------------------------------------------------------------
	// effective frame size, clamped into 2..MAX_DIM
	// ---------------------------------------------------------------
	logic [DIM_W-1:0] width_eff;
	logic [DIM_W-1:0] height_eff;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
		logic [DIM_W-1:0] ext;
		ext = DIM_W'(v);
		if (ext < DIM_W'(2)) begin
			return DIM_W'(2);
		end else if (ext > DIM_W'(MAX_DIM)) begin
			return DIM_W'(MAX_DIM);
		end
		return ext;
	endfunction

	assign width_eff  = eff_dim(frame_width_q);
	assign height_eff = eff_dim(frame_height_q);

	// ---------------------------------------------------------------
	// handshake: two-entry pipe, input register then result register
	// ---------------------------------------------------------------
	logic s1_valid_q;
	logic s2_free;
	logic s1_adv;
	logic pix_acc;

	assign s2_free   = !res_valid || !res_stall;
	assign s1_adv    = s1_valid_q && s2_free;
	assign pix_stall = s1_valid_q && !s2_free;
	assign pix_acc   = pix_valid && !pix_stall;

	// ---------------------------------------------------------------
	// raster position, evaluated on the accepted beat
	// ---------------------------------------------------------------
	logic [POS_W-1:0] column_q;
	logic [POS_W-1:0] row_q;
	logic [DIM_W-1:0] col_next;
	logic [DIM_W-1:0] row_next;
	logic             line_end;
	logic             last_row;
	logic             pos_cvalid;

	assign col_next   = DIM_W'(column_q) + DIM_W'(1);
	assign row_next   = DIM_W'(row_q) + DIM_W'(1);
	assign line_end   = col_next >= width_eff;
	assign last_row   = row_next >= height_eff;
	// top-left of a full 2x2 block: even position with a neighbor inside the frame
	assign pos_cvalid = !column_q[0] && !row_q[0] && !line_end && !last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (pix_acc) begin
			if (line_end) begin
				column_q <= '0;
				row_q    <= last_row ? '0 : row_next[POS_W-1:0];
			end else begin
				column_q <= col_next[POS_W-1:0];
			end
		end
	end

	// ---------------------------------------------------------------
	// stage 1: input register with position flags
	// ---------------------------------------------------------------
	pixel_t pix_s1;
	logic   cvalid_s1;
	logic   fend_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (pix_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			pix_s1    <= pix;
			cvalid_s1 <= pos_cvalid;
			fend_s1   <= line_end && last_row;
		end
	end

	// ---------------------------------------------------------------
	// color math: q8.16 sums, always non-negative, wrap-free in 25 bits
	// ---------------------------------------------------------------
	logic [SUM_W-1:0] r_ext;
	logic [SUM_W-1:0] g_ext;
	logic [SUM_W-1:0] b_ext;
	logic [SUM_W-1:0] y_sum;
	logic [SUM_W-1:0] u_sum;
	logic [SUM_W-1:0] v_sum;
	yuv_t             res_d;

	always_comb begin
		r_ext = SUM_W'(pix_s1.red);
		g_ext = SUM_W'(pix_s1.green);
		b_ext = SUM_W'(pix_s1.blue);
		y_sum = SUM_W'(CY_R) * r_ext + SUM_W'(CY_G) * g_ext + SUM_W'(CY_B) * b_ext;
		u_sum = OFFSET_Q + SUM_W'(C_HALF) * b_ext
			- SUM_W'(CU_R) * r_ext - SUM_W'(CU_G) * g_ext;
		v_sum = OFFSET_Q + SUM_W'(C_HALF) * r_ext
			- SUM_W'(CV_G) * g_ext - SUM_W'(CV_B) * b_ext;

		res_d.luma         = round_clamp(y_sum, LUMA_LO, LUMA_HI);
		res_d.chroma_valid = cvalid_s1;
		res_d.blue_diff    = cvalid_s1 ? round_clamp(u_sum, CHROMA_LO, CHROMA_HI) : 8'd0;
		res_d.red_diff     = cvalid_s1 ? round_clamp(v_sum, CHROMA_LO, CHROMA_HI) : 8'd0;
		res_d.frame_end    = fend_s1;
	end

	// ---------------------------------------------------------------
	// stage 2: result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (s1_adv) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res <= res_d;
		end
	end

`ifndef SYNTHESIS
	// a held input beat is never lost or overwritten
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_adv |=> s1_valid_q && $stable(pix_s1) && $stable(cvalid_s1))
		else $error("input register overwritten while waiting");

	// position stays inside the largest frame
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(DIM_W'(column_q) < DIM_W'(MAX_DIM)) && (DIM_W'(row_q) < DIM_W'(MAX_DIM)))
		else $error("raster position out of range");

	// column steps by one inside a line
	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc && !line_end |=> column_q == $past(col_next[POS_W-1:0]))
		else $error("column did not advance");

	// a chroma pixel has a right neighbor, so it cannot close the frame
	a_cv_fend: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.chroma_valid && res.frame_end))
		else $error("chroma on the last pixel of a frame");

	// chroma-carrying results sit inside their clamp ranges
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.chroma_valid |->
			res.luma >= 8'd16 && res.luma <= 8'd235 &&
			res.blue_diff >= 8'd16 && res.blue_diff <= 8'd240 &&
			res.red_diff >= 8'd16 && res.red_diff <= 8'd240)
		else $error("sample outside clamp range");
`endif

endmodule
`default_nettype wire

>>> bench/tb_rgb_to_yuv420_converter_unit.sv
// testbench for the rgb to yuv 4:2:0 converter: directed and random pixel streams, self-checking
module tb_rgb_to_yuv420_converter_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import rgbyuv_pkg::*;

	// frame dimension ceiling the block is built with
	localparam int unsigned DIM_MAX = 4096;

	// bt.601 full-range coefficients, unsigned q0.16
	localparam int unsigned K_YR     = 19595;
	localparam int unsigned K_YG     = 38470;
	localparam int unsigned K_YB     = 7471;
	localparam int unsigned K_UR     = 11076;
	localparam int unsigned K_UG     = 21692;
	localparam int unsigned K_HALF   = 32768;
	localparam int unsigned K_VG     = 27460;
	localparam int unsigned K_VB     = 5308;
	// chroma offset 128 in q8.16, and the half-lsb for round half up
	localparam int unsigned Q_OFFSET = 128 << 16;
	localparam int unsigned Q_ROUND  = 32768;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// pixel side
	logic   pix_valid = 1'b0;
	logic   pix_stall;
	pixel_t pix       = '0;

	// result side
	logic res_valid;
	logic res_stall = 1'b0;
	yuv_t res;

	// register port
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [APB_AW-1:0] paddr   = '0;
	logic [APB_DW-1:0] pwdata  = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	// mirror of the frame size registers, as written
	logic [CFG_W-1:0] cfg_width  = FRAME_WIDTH_RST;
	logic [CFG_W-1:0] cfg_height = FRAME_HEIGHT_RST;

	// raster position the block should be at for the next pixel
	int unsigned pos_col = 0;
	int unsigned pos_row = 0;

	// yuv samples still owed by the block, oldest first
	yuv_t pending_yuv [$];

	// idle chances in percent, per pixel on the sender and per cycle on the receiver
	int unsigned src_gap_pct    = 0;
	int unsigned sink_stall_pct = 0;

	int unsigned error_count = 0;
	int unsigned res_beats   = 0;

	always #5 clk = ~clk;

	rgb_to_yuv420_converter_unit #(
		.MAX_DIM (DIM_MAX)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// only the first ten are printed, the rest just counted
	function automatic void note_error(input string msg);
		error_count++;
		if (error_count <= 10) begin
			$display("[%0t] ERROR %s", $realtime, msg);
		end
	endfunction

	// register value to working dimension: below 2 acts as 2, above the ceiling as the ceiling
	function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v);
		if (v < 2) begin
			return 2;
		end
		if (v > DIM_MAX) begin
			return DIM_MAX;
		end
		return v;
	endfunction

	// q8.16 sum to an 8-bit sample: round half up, then clamp
	function automatic logic [7:0] to_sample(input int unsigned sum, input int unsigned lo,
			input int unsigned hi);
		int unsigned whole;
		whole = (sum + Q_ROUND) >> 16;
		if (whole < lo) begin
			whole = lo;
		end else if (whole > hi) begin
			whole = hi;
		end
		return 8'(whole);
	endfunction

	// yuv sample for one pixel at the current position, then step the position
	function automatic yuv_t predict_yuv(input pixel_t px);
		int unsigned w;
		int unsigned h;
		int unsigned ys;
		int unsigned us;
		int unsigned vs;
		logic        chroma;
		logic        line_done;
		logic        last_line;
		yuv_t        o;
		w  = eff_dim(cfg_width);
		h  = eff_dim(cfg_height);
		ys = K_YR * px.red + K_YG * px.green + K_YB * px.blue;
		// never negative: the offset covers the largest subtracted term
		us = Q_OFFSET + K_HALF * px.blue - K_UR * px.red - K_UG * px.green;
		vs = Q_OFFSET + K_HALF * px.red - K_VG * px.green - K_VB * px.blue;
		// chroma only at the top-left of a full 2x2 block, odd edges give none
		chroma    = !pos_col[0] && !pos_row[0] && (pos_col + 1 < w) && (pos_row + 1 < h);
		// a position past the edge after a resize also counts as the edge
		line_done = (pos_col + 1 >= w);
		last_line = (pos_row + 1 >= h);
		o              = '0;
		o.luma         = to_sample(ys, 16, 235);
		o.chroma_valid = chroma;
		if (chroma) begin
			o.blue_diff = to_sample(us, 16, 240);
			o.red_diff  = to_sample(vs, 16, 240);
		end
		o.frame_end = line_done && last_line;
		if (line_done) begin
			pos_col = 0;
			pos_row = last_line ? 0 : pos_row + 1;
		end else begin
			pos_col = pos_col + 1;
		end
		return o;
	endfunction

	// channel level biased toward the extremes so the clamps get hit
	function automatic logic [7:0] pick_level();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) begin
			return 8'h00;
		end
		if (sel == 1) begin
			return 8'hFF;
		end
		return 8'($urandom());
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t px;
		px.red   = pick_level();
		px.green = pick_level();
		px.blue  = pick_level();
		return px;
	endfunction

	// mostly small frames, now and then odd sizes or values outside the legal range
	function automatic logic [CFG_W-1:0] pick_dim();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 70) begin
			return CFG_W'($urandom_range(2, 8));
		end
		if (sel < 88) begin
			return CFG_W'($urandom_range(9, 40));
		end
		if (sel < 94) begin
			return CFG_W'($urandom_range(0, 1));
		end
		return CFG_W'($urandom_range(DIM_MAX + 1, 8191));
	endfunction

	function automatic int unsigned pick_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 10;
			2: return 25;
			default: return 50;
		endcase
	endfunction

	// register value with random junk above the field, which the block must drop
	function automatic logic [APB_DW-1:0] with_junk(input logic [CFG_W-1:0] v);
		logic [APB_DW-1:0] d;
		d = $urandom_range(0, 1) ? APB_DW'($urandom()) : '0;
		d[CFG_W-1:0] = v;
		return d;
	endfunction

	// random stall bursts on the result side
	always begin : sink_stall_gen
		@(posedge clk);
		if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
			res_stall <= 1'b1;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			res_stall <= 1'b0;
		end
	end

	// every result beat is matched against the oldest owed sample
	always @(posedge clk) begin : result_check
		yuv_t want;
		if (arst_n && res_valid && !res_stall) begin
			res_beats++;
			if (pending_yuv.size() == 0) begin
				note_error($sformatf("beat %0d: result with nothing owed: %p", res_beats, res));
			end else begin
				want = pending_yuv.pop_front();
				if (res.luma !== want.luma || res.chroma_valid !== want.chroma_valid ||
						res.blue_diff !== want.blue_diff || res.red_diff !== want.red_diff ||
						res.frame_end !== want.frame_end) begin
					note_error($sformatf(
						"beat %0d: expected y %0d cv %0b u %0d v %0d end %0b, got y %0d cv %0b u %0d v %0d end %0b",
						res_beats, want.luma, want.chroma_valid, want.blue_diff, want.red_diff,
						want.frame_end, res.luma, res.chroma_valid, res.blue_diff, res.red_diff,
						res.frame_end));
				end
			end
		end
	end

	// one pixel beat, with an optional idle burst ahead of it; valid stays up afterwards
	task automatic send_pixel(input pixel_t px);
		if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pix       <= px;
		do @(posedge clk); while (pix_stall);
		pending_yuv.push_back(predict_yuv(px));
	endtask

	// stop sending, let every owed sample come back, then let the pipe and stalls settle
	task automatic quiesce();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (pending_yuv.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// setup and access phase, then a bus idle phase so psel is never set and cleared at once
	task automatic reg_write(input reg_idx_t idx, input logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_FRAME_WIDTH) begin
			cfg_width = data[CFG_W-1:0];
		end else begin
			cfg_height = data[CFG_W-1:0];
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_read_check(input reg_idx_t idx);
		logic [CFG_W-1:0] want;
		want    = (idx == REG_FRAME_WIDTH) ? cfg_width : cfg_height;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[CFG_W-1:0] !== want) begin
			note_error($sformatf("register %s reads %0d, expected %0d", idx.name(),
				prdata[CFG_W-1:0], want));
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_frame(input logic [APB_DW-1:0] w, input logic [APB_DW-1:0] h);
		reg_write(REG_FRAME_WIDTH, w);
		reg_write(REG_FRAME_HEIGHT, h);
	endtask

	// random pixels until the raster is back at the top-left corner
	task automatic to_frame_start();
		while (pos_col != 0 || pos_row != 0) send_pixel(random_pixel());
	endtask

	// reset values, readback of both registers, extremes and junk upper bits
	task automatic test_register_access();
		reg_read_check(REG_FRAME_WIDTH);
		reg_read_check(REG_FRAME_HEIGHT);
		// a few pixels at the 640x480 reset size
		repeat (6) send_pixel(random_pixel());
		quiesce();
		reg_write(REG_FRAME_WIDTH, 32'hFFFF_FFFF);
		reg_read_check(REG_FRAME_WIDTH);
		reg_write(REG_FRAME_HEIGHT, 32'hFFFF_E000);
		reg_read_check(REG_FRAME_HEIGHT);
		set_frame(32'd2, 32'd2);
		reg_read_check(REG_FRAME_WIDTH);
		reg_read_check(REG_FRAME_HEIGHT);
		// position is past the new edge, so the next pixels close the frame
		to_frame_start();
	endtask

	// 2x2 frames so every fourth pixel carries chroma; clamp cases sit on chroma slots
	task automatic test_color_extremes();
		pixel_t shades [20];
		shades = '{
			24'hFFFF00, 24'h000000, 24'hFFFFFF, 24'h808080,  // u low clamp, y low and high
			24'h0000FF, 24'hFF0000, 24'h00FF00, 24'h0000FF,  // u high clamp
			24'h00FFFF, 24'hFFFFFF, 24'h000000, 24'h7F7F7F,  // v low clamp
			24'hFF0000, 24'h010101, 24'hFEFEFE, 24'hFF00FF,  // v high clamp
			24'h000000, 24'hFFFFFF, 24'h00FF00, 24'h123456   // black: neutral chroma
		};
		quiesce();
		set_frame(32'd2, 32'd2);
		foreach (shades[i]) send_pixel(shades[i]);
	endtask

	// the last odd column or row never yields chroma
	task automatic test_odd_frames();
		quiesce();
		set_frame(32'd3, 32'd3);
		repeat (9) send_pixel(random_pixel());
		quiesce();
		set_frame(32'd2, 32'd3);
		repeat (6) send_pixel(random_pixel());
		quiesce();
		set_frame(32'd3, 32'd2);
		repeat (6) send_pixel(random_pixel());
	endtask

	// sizes below the minimum act as 2x2, with junk above the field
	task automatic test_tiny_dims();
		quiesce();
		set_frame(32'hFFFF_E000, 32'h0000_2001);
		repeat (4) send_pixel(random_pixel());
		quiesce();
		set_frame(32'd1, 32'd0);
		repeat (4) send_pixel(random_pixel());
	endtask

	// shrink the frame under the current position: the next pixel ends line and frame
	task automatic test_resize_mid_frame();
		quiesce();
		set_frame(32'd8, 32'd8);
		repeat (13) send_pixel(random_pixel());
		quiesce();
		set_frame(32'd4, 32'd2);
		repeat (9) send_pixel(random_pixel());
		// grow it again, now back at the top-left corner
		quiesce();
		set_frame(32'd6, 32'd4);
		repeat (20) send_pixel(random_pixel());
	endtask

	// a long line with the width register far above the ceiling: no early line end
	task automatic test_widest_line();
		quiesce();
		set_frame(32'd2, 32'd2);
		to_frame_start();
		src_gap_pct    = 0;
		sink_stall_pct = 0;
		quiesce();
		set_frame(32'd8191, 32'd3);
		repeat (64) send_pixel(random_pixel());
	endtask

	// random frame sizes with well-formed frames of random content, some cut short
	task automatic test_random_frames(input int unsigned n_items);
		int unsigned sent;
		int unsigned frame_px;
		int unsigned burst;
		sent = 0;
		while (sent < n_items) begin
			quiesce();
			src_gap_pct    = pick_pct();
			sink_stall_pct = pick_pct();
			case ($urandom_range(0, 3))
				0: reg_write(REG_FRAME_WIDTH, with_junk(pick_dim()));
				1: reg_write(REG_FRAME_HEIGHT, with_junk(pick_dim()));
				default: set_frame(with_junk(pick_dim()), with_junk(pick_dim()));
			endcase
			frame_px = eff_dim(cfg_width) * eff_dim(cfg_height);
			if (frame_px <= 400) begin
				burst = frame_px * $urandom_range(1, 2);
				// now and then stop mid-frame so the next size lands on a live position
				if ($urandom_range(0, 3) == 0) begin
					burst = burst + $urandom_range(1, frame_px);
				end
			end else begin
				burst = $urandom_range(20, 150);
			end
			if (burst > n_items - sent) begin
				burst = n_items - sent;
			end
			repeat (burst) send_pixel(random_pixel());
			sent = sent + burst;
		end
	endtask

	// back-to-back beats with no idling on either side
	task automatic test_steady_stream();
		src_gap_pct    = 0;
		sink_stall_pct = 0;
		quiesce();
		set_frame(APB_DW'($urandom_range(2, 16)), APB_DW'($urandom_range(2, 16)));
		repeat (200) send_pixel(random_pixel());
	endtask

	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part with moderate idling on both sides
		src_gap_pct    = 20;
		sink_stall_pct = 20;
		test_register_access();
		test_color_extremes();
		test_odd_frames();
		test_tiny_dims();
		test_resize_mid_frame();
		test_widest_line();

		test_random_frames(1330);
		test_steady_stream();

		// nothing owed any more, plus a few cycles to catch stray beats
		quiesce();
		if (error_count == 0) begin
			$display("rgb_to_yuv420_converter_unit verification clean");
		end else begin
			$display("rgb_to_yuv420_converter_unit verification failed");
		end
		$finish;
	end

	// generous bound on the whole run, many times the slowest legal run
	initial begin : watchdog
		#5ms;
		$display("rgb_to_yuv420_converter_unit verification failed");
		$finish;
	end

endmodule
